FILE: hw/rtl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg: shared definitions for the multi-channel sine pulser
// Sizes, operation codes, sequencer states and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int NUM_LIGHTS    = 9;
    localparam int PHASE_BITS    = 16;
    localparam int LUT_ADDR_BITS = 8;

    // Fixed field widths of the channels
    localparam int SEL_W       = 4;
    localparam int LOAD_W      = 16;
    localparam int LIGHT_NUM_W = 4;
    localparam int INTENSITY_W = 13;

    localparam int LIGHT_IDX_W = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;
    localparam int LUT_DEPTH   = 1 << LUT_ADDR_BITS;
    localparam int SINE_W      = 12;
    localparam int FRAC_W      = PHASE_BITS - 2;
    localparam int ADDR_SHR    = (FRAC_W >= LUT_ADDR_BITS) ? FRAC_W - LUT_ADDR_BITS : 0;
    localparam int ADDR_SHL    = (FRAC_W >= LUT_ADDR_BITS) ? 0 : LUT_ADDR_BITS - FRAC_W;
    localparam int FRAC_EXT_W  = FRAC_W + ADDR_SHL;

    localparam logic [LIGHT_IDX_W-1:0] LAST_LIGHT = LIGHT_IDX_W'(NUM_LIGHTS - 1);
    localparam logic [INTENSITY_W-1:0] MID_LEVEL  = INTENSITY_W'(2048);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_TICK
    } seq_state_t;

    // Handoff from the sequencer to the sine output stage
    typedef struct packed {
        logic                   fire;
        logic [LIGHT_IDX_W-1:0] light;
        logic                   last;
    } sine_req_t;

    // Q30 Taylor coefficients of sin(pi/2 * x)
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] C1      = 64'd1686629713;
    localparam logic [63:0] C3      = 64'd693598678;
    localparam logic [63:0] C5      = 64'd85569306;
    localparam logic [63:0] C7      = 64'd5026995;
    localparam logic [63:0] C9      = 64'd172272;

    // Quarter-wave entry for address a in 0..LUT_DEPTH; elaboration time only
    function automatic logic [SINE_W-1:0] quarter_sine(int unsigned a);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] r;
        x = 64'(a) << (30 - LUT_ADDR_BITS);
        if (x > Q30_ONE)
            x = Q30_ONE;
        x2 = (x * x) >> 30;
        p  = C7 - ((x2 * C9) >> 30);
        p  = C5 - ((x2 * p) >> 30);
        p  = C3 - ((x2 * p) >> 30);
        p  = C1 - ((x2 * p) >> 30);
        s  = (x * p) >> 30;
        r  = (s * 64'd2048 + (64'd1 << 29)) >> 30;
        if (r > 64'd2048)
            r = 64'd2048;
        return SINE_W'(r);
    endfunction

    typedef logic [SINE_W-1:0] sine_lut_t [LUT_DEPTH];

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t t;
        for (int a = 0; a < LUT_DEPTH; a++)
            t[a] = quarter_sine(a);
        return t;
    endfunction

    localparam sine_lut_t         SINE_LUT = build_sine_lut();
    // Entry at the quarter point itself, just past the table
    localparam logic [SINE_W-1:0] SINE_TOP = quarter_sine(LUT_DEPTH);

endpackage

FILE: hw/rtl/msp_if.sv
// ----------------------------------------------------------------------------
// msp_if: channel interfaces of the multi-channel sine pulser
// Valid/ready channels for command transactions and intensity results.
// ----------------------------------------------------------------------------
interface msp_in_if;
    import msp_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [SEL_W-1:0]  light_select;
    logic [LOAD_W-1:0] start_phase;
    logic [LOAD_W-1:0] phase_step;

    modport source (output valid, output opcode, output light_select,
                    output start_phase, output phase_step, input ready);
    modport sink   (input valid, input opcode, input light_select,
                    input start_phase, input phase_step, output ready);
endinterface

interface msp_out_if;
    import msp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [LIGHT_NUM_W-1:0] light_number;
    logic [INTENSITY_W-1:0] intensity;
    logic                   last;

    modport source (output valid, output light_number, output intensity,
                    output last, input ready);
    modport sink   (input valid, input light_number, input intensity,
                    input last, output ready);
endinterface

FILE: hw/rtl/multi_channel_sine_pulser.sv
// ----------------------------------------------------------------------------
// multi_channel_sine_pulser: bank of sine oscillators, one per light
// Phase accumulators in a ring of cells, read out through one sine table.
// ----------------------------------------------------------------------------
//  channel  | dir | fields                                          | role
//  cmd      | in  | opcode, light_select, start_phase, phase_step   | tick/load
//  result   | out | light_number, intensity, last                   | per light
//
//  A load transaction is written into its cell as it is accepted and does not
//  hold the command channel. A tick holds it from the accepting cycle through
//  the walk: one ring shift and one sine lookup per result, each waiting for a free output slot.
//  Reset clears every phase, every step and the sequencer; a stalled result
//  freezes the ring, and the next command is taken once the last result of
//  the tick sits in the output register.
// ----------------------------------------------------------------------------
module multi_channel_sine_pulser (
    input  logic      clk,
    input  logic      rst_n,
    msp_in_if.sink    cmd,
    msp_out_if.source result
);
    import msp_pkg::*;

    seq_state_t             state_reg;
    seq_state_t             state_next;
    logic [LIGHT_IDX_W-1:0] seq_reg;
    logic [LIGHT_IDX_W-1:0] seq_next;

    logic                   accept;
    logic                   free;
    logic                   shift_en;
    sine_req_t              req;
    logic [PHASE_BITS-1:0]  load_phase;
    logic [PHASE_BITS-1:0]  load_step;
    logic [PHASE_BITS-1:0]  phase_q [NUM_LIGHTS];
    logic [PHASE_BITS-1:0]  step_q  [NUM_LIGHTS];
    logic [PHASE_BITS-1:0]  wrap_phase;

    // Command side: ready only between ticks
    assign cmd.ready  = (state_reg == ST_IDLE);
    assign accept     = cmd.valid && cmd.ready;
    assign load_phase = PHASE_BITS'(cmd.start_phase);
    assign load_step  = PHASE_BITS'(cmd.phase_step);

    // Sequencer: walk the lights, one per free output slot
    always_comb
    begin
        state_next = state_reg;
        seq_next   = seq_reg;
        shift_en   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.opcode == OP_TICK)
                begin
                    state_next = ST_TICK;
                    seq_next   = '0;
                end
            end
            ST_TICK:
            begin
                if (free)
                begin
                    shift_en = 1'b1;
                    if (seq_reg == LAST_LIGHT)
                    begin
                        state_next = ST_IDLE;
                        seq_next   = '0;
                    end
                    else
                    begin
                        seq_next = seq_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                seq_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seq_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
        end
    end

    // Head cell feeds the sine stage; its advanced phase re-enters at the tail
    assign wrap_phase = phase_q[0] + step_q[0];

    genvar i;
    generate
        for (i = 0; i < NUM_LIGHTS; i++)
        begin : g_cell
            logic                  load_en;
            logic [PHASE_BITS-1:0] in_phase;
            logic [PHASE_BITS-1:0] in_step;

            assign load_en = accept && (cmd.opcode == OP_LOAD)
                             && (32'(cmd.light_select) == 32'(i));

            if (i == NUM_LIGHTS - 1)
            begin : g_tail
                assign in_phase = wrap_phase;
                assign in_step  = step_q[0];
            end
            else
            begin : g_body
                assign in_phase = phase_q[i+1];
                assign in_step  = step_q[i+1];
            end

            msp_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .load_en     (load_en),
                .load_phase  (load_phase),
                .load_step   (load_step),
                .shift_en    (shift_en),
                .shift_phase (in_phase),
                .shift_step  (in_step),
                .phase       (phase_q[i]),
                .step        (step_q[i])
            );
        end
    endgenerate

    // Hand the head light to the output stage on every shift
    assign req.fire  = shift_en;
    assign req.light = seq_reg;
    assign req.last  = (seq_reg == LAST_LIGHT);

    msp_sine u_sine (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .phase  (phase_q[0]),
        .free   (free),
        .result (result)
    );

    // The ring moves only while a tick is in progress
    a_shift_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !shift_en)
        else $error("ring shifted outside a tick");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        req.fire |-> (!result.valid || result.ready))
        else $error("result register overwritten");

    // The final result of a tick carries the highest light number
    a_last_light: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.last) |->
        (result.light_number == LIGHT_NUM_W'(LAST_LIGHT)))
        else $error("last flag on wrong light");

    // An accepted tick starts the walk in the next cycle
    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.opcode == OP_TICK) |=> (state_reg == ST_TICK && seq_reg == '0))
        else $error("tick did not start");

endmodule

FILE: hw/rtl/msp_cell.sv
// ----------------------------------------------------------------------------
// msp_cell: one light's phase accumulator cell
// Holds phase and step; loads directly or takes its neighbor's pair on shift.
// ----------------------------------------------------------------------------
module msp_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load_en,
    input  logic [msp_pkg::PHASE_BITS-1:0]    load_phase,
    input  logic [msp_pkg::PHASE_BITS-1:0]    load_step,
    input  logic                              shift_en,
    input  logic [msp_pkg::PHASE_BITS-1:0]    shift_phase,
    input  logic [msp_pkg::PHASE_BITS-1:0]    shift_step,
    output logic [msp_pkg::PHASE_BITS-1:0]    phase,
    output logic [msp_pkg::PHASE_BITS-1:0]    step
);
    import msp_pkg::*;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [PHASE_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0] step_next;

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        if (shift_en)
        begin
            phase_next = shift_phase;
            step_next  = shift_step;
        end
        else if (load_en)
        begin
            phase_next = load_phase;
            step_next  = load_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    assign phase = phase_reg;
    assign step  = step_reg;

endmodule

FILE: hw/rtl/msp_sine.sv
// ----------------------------------------------------------------------------
// msp_sine: sine lookup and result register
// Maps a phase to an intensity through the quarter-wave table and holds it.
// ----------------------------------------------------------------------------
module msp_sine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  msp_pkg::sine_req_t             req,
    input  logic [msp_pkg::PHASE_BITS-1:0] phase,
    output logic                           free,
    msp_out_if.source                      result
);
    import msp_pkg::*;

    logic [1:0]               quad;
    logic [FRAC_W-1:0]        frac;
    logic [LUT_ADDR_BITS-1:0] addr;
    logic [LUT_ADDR_BITS:0]   mirror;
    logic [SINE_W-1:0]        level;
    logic [INTENSITY_W-1:0]   intensity_calc;

    logic                   valid_reg;
    logic                   valid_next;
    logic [LIGHT_NUM_W-1:0] light_reg;
    logic [INTENSITY_W-1:0] intensity_reg;
    logic                   last_reg;

    always_comb
    begin
        quad = phase[PHASE_BITS-1 -: 2];
        frac = phase[FRAC_W-1:0];
        addr = LUT_ADDR_BITS'((FRAC_EXT_W'(frac) << ADDR_SHL) >> ADDR_SHR);
        // Mirror the address in the odd quadrants
        if (quad[0])
            mirror = (LUT_ADDR_BITS+1)'(LUT_DEPTH) - {1'b0, addr};
        else
            mirror = {1'b0, addr};
        if (mirror[LUT_ADDR_BITS])
            level = SINE_TOP;
        else
            level = SINE_LUT[mirror[LUT_ADDR_BITS-1:0]];
        if (quad[1])
            intensity_calc = MID_LEVEL - INTENSITY_W'(level);
        else
            intensity_calc = MID_LEVEL + INTENSITY_W'(level);
    end

    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.fire)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (req.fire)
        begin
            light_reg     <= LIGHT_NUM_W'(req.light);
            intensity_reg <= intensity_calc;
            last_reg      <= req.last;
        end
    end

    assign result.valid        = valid_reg;
    assign result.light_number = light_reg;
    assign result.intensity    = intensity_reg;
    assign result.last         = last_reg;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multi_channel_sine_pulser
// Drives load and tick commands over the command channel and checks every
// per-light intensity against a local phase-accumulator bank and sine table.
// A short directed table comes first, then random traffic. Both channels
// stall in random bursts, and the tail runs with no stalls.
// ----------------------------------------------------------------------------
module testbench;
    import msp_pkg::*;

    // Run shape
    localparam int RANDOM_ITEMS   = 285;
    localparam int TAIL_ITEMS     = 40;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;
    localparam logic [SEL_W-1:0] NO_PIN = 4'hF;

    // Q30 coefficients of the Taylor series of sin(pi/2 * x)
    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned K1      = 64'd1686629713;
    localparam longint unsigned K3      = 64'd693598678;
    localparam longint unsigned K5      = 64'd85569306;
    localparam longint unsigned K7      = 64'd5026995;
    localparam longint unsigned K9      = 64'd172272;

    // One row of the directed table. pin_light names a light whose intensity
    // on this tick is known by inspection; pin_lvl is that intensity.
    typedef struct packed {
        logic                   op;
        logic [SEL_W-1:0]       sel;
        logic [LOAD_W-1:0]      ph;
        logic [LOAD_W-1:0]      st;
        logic [SEL_W-1:0]       pin_light;
        logic [INTENSITY_W-1:0] pin_lvl;
    } stim_row_t;

    // One intensity the block owes us
    typedef struct {
        logic [LIGHT_NUM_W-1:0] light;
        logic [INTENSITY_W-1:0] level;
        logic                   last;
    } light_level_t;

    localparam int PLAN_LEN = 25;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    msp_in_if  cmd_ch ();
    msp_out_if res_ch ();

    multi_channel_sine_pulser uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Local copy of the oscillator bank
    logic [PHASE_BITS-1:0] phase_bank [NUM_LIGHTS];
    logic [PHASE_BITS-1:0] step_bank  [NUM_LIGHTS];
    logic [SINE_W-1:0]     quarter_wave [0:LUT_DEPTH];

    light_level_t levels_due [$];
    stim_row_t    plan [PLAN_LEN];

    int  fail_count      = 0;
    int  results_checked = 0;
    int  ticks_sent      = 0;
    int  loads_sent      = 0;
    int  loads_dropped   = 0;
    int  idle_cycles     = 0;
    bit  quiet_tail      = 1'b0;

    // ------------------------------------------------------------------------
    // Sine prediction
    // ------------------------------------------------------------------------

    // Quarter-wave entry for address a: Horner evaluation in Q30, each
    // product truncated, then rounded to 2048 full scale and capped there.
    function automatic logic [SINE_W-1:0] poly_quarter(int unsigned a);
        longint unsigned x;
        longint unsigned xx;
        longint unsigned acc;
        longint unsigned y;
        x = longint'(a) << (30 - LUT_ADDR_BITS);
        if (x > ONE_Q30)
            x = ONE_Q30;
        xx  = (x * x) >> 30;
        acc = K7 - ((xx * K9) >> 30);
        acc = K5 - ((xx * acc) >> 30);
        acc = K3 - ((xx * acc) >> 30);
        acc = K1 - ((xx * acc) >> 30);
        y   = (x * acc) >> 30;
        y   = (y * 64'd2048 + (64'd1 << 29)) >> 30;
        if (y > 64'd2048)
            y = 64'd2048;
        return SINE_W'(y);
    endfunction

    // Intensity of one phase: top two bits pick the quadrant, odd quadrants
    // mirror the address, the lower half-wave subtracts from mid level.
    function automatic logic [INTENSITY_W-1:0] sine_level(logic [PHASE_BITS-1:0] ph);
        logic [1:0]             quad;
        int unsigned            addr;
        logic [INTENSITY_W-1:0] t;
        quad = ph[PHASE_BITS-1 -: 2];
        addr = 32'(ph[PHASE_BITS-3 -: LUT_ADDR_BITS]);
        if (quad[0])
            addr = LUT_DEPTH - addr;
        t = INTENSITY_W'(quarter_wave[addr]);
        return quad[1] ? MID_LEVEL - t : MID_LEVEL + t;
    endfunction

    function automatic void note_fail(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ERROR: %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Present one transaction, hold it until the handshake, then update the
    // local bank. A tick queues one intensity per light, in light order.
    task automatic issue_cmd(input logic op, input logic [SEL_W-1:0] sel,
                             input logic [LOAD_W-1:0] ph, input logic [LOAD_W-1:0] st,
                             input logic [SEL_W-1:0] pin_light,
                             input logic [INTENSITY_W-1:0] pin_lvl);
        light_level_t e;
        cmd_ch.valid        <= 1'b1;
        cmd_ch.opcode       <= op;
        cmd_ch.light_select <= sel;
        cmd_ch.start_phase  <= ph;
        cmd_ch.phase_step   <= st;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (op == OP_LOAD)
        begin
            loads_sent++;
            // Lights past the end of the bank are dropped silently
            if (sel < NUM_LIGHTS)
            begin
                phase_bank[sel] = ph[PHASE_BITS-1:0];
                step_bank[sel]  = st[PHASE_BITS-1:0];
            end
            else
                loads_dropped++;
        end
        else
        begin
            ticks_sent++;
            for (int k = 0; k < NUM_LIGHTS; k++)
            begin
                e.light = LIGHT_NUM_W'(k);
                e.level = (pin_light == k) ? pin_lvl : sine_level(phase_bank[k]);
                e.last  = (k == NUM_LIGHTS - 1);
                levels_due.push_back(e);
                // Advance after the read; the add wraps at 2 pi
                phase_bank[k] = phase_bank[k] + step_bank[k];
            end
        end
    endtask

    // Drop valid for a random burst of idle cycles
    task automatic sender_pause();
        cmd_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 14))
            @(posedge clk);
    endtask

    // Drop valid and hold off until every queued intensity has come back
    task automatic wait_drain();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (levels_due.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random backpressure in bursts, with calm stretches
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int hold;
        bit stall_mode;
        stall_mode = 1'b1;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!quiet_tail && stall_mode && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(1, 14);
                res_ch.ready <= 1'b0;
                repeat (hold)
                    @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            // Flip between stalling and calm stretches now and then
            if ($urandom_range(0, 79) == 0)
                stall_mode = !stall_mode;
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        light_level_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_checked++;
            if (levels_due.size() == 0)
                note_fail($sformatf("unexpected result light=%0d level=%0d last=%0d",
                                    res_ch.light_number, res_ch.intensity, res_ch.last));
            else
            begin
                e = levels_due.pop_front();
                if (res_ch.light_number !== e.light || res_ch.intensity !== e.level
                    || res_ch.last !== e.last)
                    note_fail($sformatf(
                        "expected light=%0d level=%0d last=%0d, got light=%0d level=%0d last=%0d",
                        e.light, e.level, e.last,
                        res_ch.light_number, res_ch.intensity, res_ch.last));
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either channel
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no transaction for %0d cycles, %0d results pending",
                     $time, idle_cycles, levels_due.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic              op;
        logic [SEL_W-1:0]  sel;
        logic [LOAD_W-1:0] ph;
        logic [LOAD_W-1:0] st;
        bit                gappy;

        for (int a = 0; a <= LUT_DEPTH; a++)
            quarter_wave[a] = poly_quarter(a);
        for (int k = 0; k < NUM_LIGHTS; k++)
        begin
            phase_bank[k] = '0;
            step_bank[k]  = '0;
        end

        // Directed table. Pinned levels: every phase is zero after reset;
        // a phase of a quarter turn reads full scale, three quarters reads
        // zero, a half turn reads mid level; a step of zero holds the light.
        plan = '{
            '{OP_TICK, 4'd0,  16'h0000, 16'h0000, 4'd0,   13'd2048}, // after reset
            '{OP_LOAD, 4'd0,  16'h4000, 16'h4000, NO_PIN, 13'd0},
            '{OP_LOAD, 4'd8,  16'hC000, 16'hFFFF, NO_PIN, 13'd0},
            '{OP_LOAD, 4'd9,  16'h1234, 16'h1111, NO_PIN, 13'd0},    // out of range
            '{OP_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, NO_PIN, 13'd0},    // out of range
            '{OP_TICK, 4'd0,  16'h0000, 16'h0000, 4'd8,   13'd0},
            '{OP_TICK, 4'd15, 16'hFFFF, 16'hFFFF, 4'd0,   13'd2048},
            '{OP_TICK, 4'd0,  16'h0000, 16'h0000, 4'd0,   13'd0},
            '{OP_LOAD, 4'd1,  16'hFFFF, 16'h0001, NO_PIN, 13'd0},
            '{OP_TICK, 4'd0,  16'h0000, 16'h0000, NO_PIN, 13'd0},
            '{OP_TICK, 4'd0,  16'h0000, 16'h0000, 4'd1,   13'd2048}, // wrapped to 0
            '{OP_LOAD, 4'd2,  16'h7FFF, 16'h8000, NO_PIN, 13'd0},
            '{OP_LOAD, 4'd3,  16'h0000, 16'h0000, NO_PIN, 13'd0},
            '{OP_LOAD, 4'd4,  16'hAAAA, 16'h5555, NO_PIN, 13'd0},
            '{OP_LOAD, 4'd5,  16'h5555, 16'hAAAA, NO_PIN, 13'd0},
            '{OP_LOAD, 4'd6,  16'h2000, 16'h0040, NO_PIN, 13'd0},
            '{OP_LOAD, 4'd7,  16'hFFFF, 16'hFFFF, NO_PIN, 13'd0},
            '{OP_TICK, 4'd0,  16'h0000, 16'h0000, 4'd3,   13'd2048},
            '{OP_TICK, 4'd0,  16'h0000, 16'h0000, NO_PIN, 13'd0},
            '{OP_LOAD, 4'd8,  16'h4000, 16'h0000, NO_PIN, 13'd0},
            '{OP_TICK, 4'd0,  16'h0000, 16'h0000, 4'd8,   13'd4096},
            '{OP_TICK, 4'd0,  16'h0000, 16'h0000, 4'd8,   13'd4096},
            '{OP_LOAD, 4'd0,  16'h0000, 16'h8000, NO_PIN, 13'd0},
            '{OP_TICK, 4'd0,  16'h0000, 16'h0000, 4'd0,   13'd2048},
            '{OP_TICK, 4'd0,  16'h0000, 16'h0000, 4'd0,   13'd2048}
        };

        // Hold every command input at a known value through reset
        cmd_ch.valid        <= 1'b0;
        cmd_ch.opcode       <= OP_TICK;
        cmd_ch.light_select <= '0;
        cmd_ch.start_phase  <= '0;
        cmd_ch.phase_step   <= '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table, with the odd idle burst in between
        for (int r = 0; r < PLAN_LEN; r++)
        begin
            if ($urandom_range(0, 3) == 0)
                sender_pause();
            issue_cmd(plan[r].op, plan[r].sel, plan[r].ph, plan[r].st,
                      plan[r].pin_light, plan[r].pin_lvl);
        end
        wait_drain();

        // Random traffic: loads and ticks mixed, mostly lights in range, steps
        // drawn from zero, full scale, small and arbitrary values
        gappy = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                wait_drain();
            if (i == RANDOM_ITEMS - TAIL_ITEMS)
                quiet_tail = 1'b1;
            if (i % 20 == 0)
                gappy = 1'($urandom_range(0, 1));
            if (!quiet_tail && gappy && $urandom_range(0, 2) == 0)
                sender_pause();

            op  = ($urandom_range(0, 99) < 45) ? OP_TICK : OP_LOAD;
            sel = ($urandom_range(0, 99) < 85) ? SEL_W'($urandom_range(0, NUM_LIGHTS - 1))
                                               : SEL_W'($urandom_range(NUM_LIGHTS, 15));
            ph  = LOAD_W'($urandom);
            case ($urandom_range(0, 4))
                0:       st = '0;
                1:       st = '1;
                2:       st = LOAD_W'($urandom_range(1, 16'h0200));
                default: st = LOAD_W'($urandom);
            endcase
            issue_cmd(op, sel, ph, st, NO_PIN, '0);
        end

        // Let the last tick drain, then give stray results time to show up
        wait_drain();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (levels_due.size() != 0)
            note_fail($sformatf("%0d expected results never arrived", levels_due.size()));

        $display("Sent %0d ticks and %0d loads (%0d to lights past the bank).",
                 ticks_sent, loads_sent, loads_dropped);
        $display("Checked %0d intensity results; %0d failures.", results_checked, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/msp_pkg.sv
hw/rtl/msp_if.sv
hw/rtl/msp_cell.sv
hw/rtl/msp_sine.sv
hw/rtl/multi_channel_sine_pulser.sv
tb/testbench.sv
